[rtl/core/sirt_pkg.sv]
`timescale 1ns / 1ps

package sirt_pkg;

    // Largest radix the alphabet registers can describe.
    localparam int MAX_RADIX_DEF = 16;

    localparam int VALUE_W  = 32;
    localparam int DIGIT_W  = 4;
    localparam int RADIX_W  = 5;
    localparam int SYM_W    = 8;
    localparam int ALPHA_W  = 64;
    localparam int CFG_IDX_W = 2;
    localparam int MAX_DIGITS = 32;
    localparam int COUNT_W  = 6;
    localparam int STEP_W   = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RADIX      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA_HIGH = 2'd2;

    localparam logic [SYM_W-1:0] SIGN_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] SIGN_MINUS = 8'h2D;

    typedef struct packed {
        logic done;
        logic ok;
    } chk_status_t;

    typedef struct packed {
        logic                 done;
        logic [VALUE_W-1:0]   quotient;
        logic [DIGIT_W-1:0]   remainder;
    } div_result_t;

    // Symbol byte for one digit, taken from the two alphabet registers.
    function automatic logic [SYM_W-1:0] symbol_of(
        input logic [ALPHA_W-1:0] alpha_low,
        input logic [ALPHA_W-1:0] alpha_high,
        input logic [DIGIT_W-1:0] digit
    );
        logic [ALPHA_W-1:0] word;
        word = digit[3] ? alpha_high : alpha_low;
        return word[{digit[2:0], 3'b000} +: SYM_W];
    endfunction

endpackage

[rtl/core/signed_integer_to_radix_text.sv]
// Only one input item is in flight at a time. It first goes through the alphabet check
// and is dropped if that fails; a negative value then emits a minus sign; a nonzero value
// goes through the shared bit-serial divider once per digit (a load step plus 32
// shift-subtract steps), then the symbols leave one per cycle while the output takes them.
// Reset: rst_n is asynchronous and active low; it returns the sequencer to idle and clears
// the output valid and all configuration registers to zero.
`timescale 1ns / 1ps

module signed_integer_to_radix_text
#(
    parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // Input item: tdata[31:0] = value (signed).
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [sirt_pkg::VALUE_W-1:0]        s_tdata,
    // Output item: tdata[7:0] = symbol; tlast marks the final symbol of a value's text.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [sirt_pkg::SYM_W-1:0]          m_tdata,
    output logic                                m_tlast,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [sirt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sirt_pkg::ALPHA_W-1:0]        cfg_data
);

    // Sequencer states, one-hot.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CHECK = 5'b00010,
        S_SIGN  = 5'b00100,
        S_DIV   = 5'b01000,
        S_EMIT  = 5'b10000
    } state_t;

    localparam int STACK_W = sirt_pkg::MAX_DIGITS * sirt_pkg::DIGIT_W;

    state_t                             state_reg, state_next;
    logic                               neg_reg, neg_next;
    logic [sirt_pkg::VALUE_W-1:0]       mag_reg, mag_next;
    logic [STACK_W-1:0]                 stack_reg, stack_next;
    logic [sirt_pkg::COUNT_W-1:0]       count_reg, count_next;

    logic                               out_valid_reg, out_valid_next;
    logic [sirt_pkg::SYM_W-1:0]         out_sym_reg, out_sym_next;
    logic                               out_last_reg, out_last_next;

    logic [sirt_pkg::RADIX_W-1:0]       radix_reg;
    logic [sirt_pkg::ALPHA_W-1:0]       alpha_low_reg;
    logic [sirt_pkg::ALPHA_W-1:0]       alpha_high_reg;

    logic                               chk_start;
    sirt_pkg::chk_status_t              chk_status;
    logic                               div_start;
    sirt_pkg::div_result_t              div_result;
    logic                               out_free;
    logic                               in_accept;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    // The output register may be loaded when empty or when its item leaves this cycle.
    assign out_free  = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sym_reg;
    assign m_tlast  = out_last_reg;

    // Configuration registers; writes to an index beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg      <= '0;
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sirt_pkg::REG_RADIX:      radix_reg      <= cfg_data[sirt_pkg::RADIX_W-1:0];
                sirt_pkg::REG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                sirt_pkg::REG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                default:                  ;
            endcase
        end
    end

    sirt_alpha_check
    #(
        .MAX_RADIX (MAX_RADIX)
    )
    u_check
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (chk_start),
        .radix      (radix_reg),
        .alpha_low  (alpha_low_reg),
        .alpha_high (alpha_high_reg),
        .status     (chk_status)
    );

    // The divider loads the value the magnitude register is about to take, so a new
    // division can start on the quotient in the same cycle the previous one finishes.
    sirt_divider u_divider
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (mag_next),
        .divisor  (radix_reg),
        .result   (div_result)
    );

    // Digits are pushed least significant first into the low end of the stack and
    // popped from the same end, so they leave most significant first.
    always_comb
    begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        mag_next       = mag_reg;
        stack_next     = stack_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_sym_next   = out_sym_reg;
        out_last_next  = out_last_reg;
        chk_start      = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    neg_next   = s_tdata[sirt_pkg::VALUE_W-1];
                    // The magnitude of the most negative value wraps to itself, which is
                    // exactly its unsigned magnitude.
                    mag_next   = s_tdata[sirt_pkg::VALUE_W-1] ? (~s_tdata + 1'b1) : s_tdata;
                    count_next = '0;
                    chk_start  = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (chk_status.done)
                begin
                    if (!chk_status.ok)
                    begin
                        state_next = S_IDLE;
                    end
                    else if (mag_reg == '0)
                    begin
                        // Zero is the digit-zero symbol alone.
                        stack_next = '0;
                        count_next = sirt_pkg::COUNT_W'(1);
                        state_next = S_EMIT;
                    end
                    else if (neg_reg)
                    begin
                        state_next = S_SIGN;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIV;
                    end
                end
            end
            S_SIGN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = sirt_pkg::SIGN_MINUS;
                    out_last_next  = 1'b0;
                    div_start      = 1'b1;
                    state_next     = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_result.done)
                begin
                    stack_next = {stack_reg[STACK_W-sirt_pkg::DIGIT_W-1:0], div_result.remainder};
                    count_next = count_reg + 1'b1;
                    mag_next   = div_result.quotient;
                    if (div_result.quotient == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_start = 1'b1;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_sym_next   = sirt_pkg::symbol_of(alpha_low_reg, alpha_high_reg,
                                                         stack_reg[sirt_pkg::DIGIT_W-1:0]);
                    out_last_next  = (count_reg == sirt_pkg::COUNT_W'(1));
                    stack_next     = {{sirt_pkg::DIGIT_W{1'b0}},
                                      stack_reg[STACK_W-1:sirt_pkg::DIGIT_W]};
                    count_next     = count_reg - 1'b1;
                    if (count_reg == sirt_pkg::COUNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        stack_reg    <= stack_next;
        out_sym_reg  <= out_sym_next;
        out_last_reg <= out_last_next;
    end

endmodule

[rtl/core/sirt_divider.sv]
`timescale 1ns / 1ps

// Restoring bit-serial divider: a load step, then one quotient bit per cycle until done.
module sirt_divider
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sirt_pkg::VALUE_W-1:0]      dividend,
    input  logic [sirt_pkg::RADIX_W-1:0]      divisor,
    output sirt_pkg::div_result_t             result
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [sirt_pkg::STEP_W-1:0]      step_reg, step_next;
    logic [sirt_pkg::VALUE_W-1:0]     quo_reg, quo_next;
    logic [sirt_pkg::DIGIT_W-1:0]     rem_reg, rem_next;
    logic [sirt_pkg::RADIX_W-1:0]     trial;
    logic [sirt_pkg::RADIX_W-1:0]     diff;
    logic                             fits;

    assign trial = {rem_reg, quo_reg[sirt_pkg::VALUE_W-1]};
    assign fits  = (trial >= divisor);
    assign diff  = trial - divisor;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        if (start && !busy_reg)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            quo_next  = {quo_reg[sirt_pkg::VALUE_W-2:0], fits};
            rem_next  = fits ? diff[sirt_pkg::DIGIT_W-1:0] : trial[sirt_pkg::DIGIT_W-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == sirt_pkg::STEP_W'(sirt_pkg::VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign result.done      = done_reg;
    assign result.quotient  = quo_reg;
    assign result.remainder = rem_reg;

endmodule

[rtl/core/sirt_alpha_check.sv]
`timescale 1ns / 1ps

// Walks used symbols one per cycle; rejects a bad radix, signs and duplicates.
module sirt_alpha_check
#(
    parameter int MAX_RADIX = sirt_pkg::MAX_RADIX_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [sirt_pkg::RADIX_W-1:0]      radix,
    input  logic [sirt_pkg::ALPHA_W-1:0]      alpha_low,
    input  logic [sirt_pkg::ALPHA_W-1:0]      alpha_high,
    output sirt_pkg::chk_status_t             status
);

    logic                           busy_reg, busy_next;
    logic [sirt_pkg::DIGIT_W-1:0]   idx_reg, idx_next;
    logic [sirt_pkg::SYM_W-1:0]     sym_cur;
    logic                           range_bad;
    logic                           sign_bad;
    logic                           dup;
    logic                           at_end;

    assign sym_cur   = sirt_pkg::symbol_of(alpha_low, alpha_high, idx_reg);
    assign range_bad = (radix < sirt_pkg::RADIX_W'(2))
                     || (radix > sirt_pkg::RADIX_W'(MAX_RADIX));
    assign sign_bad  = (sym_cur == sirt_pkg::SIGN_PLUS) || (sym_cur == sirt_pkg::SIGN_MINUS);
    assign at_end    = ({1'b0, idx_reg} == (radix - sirt_pkg::RADIX_W'(1)));

    always_comb
    begin
        dup = 1'b0;
        for (int j = 0; j < 16; j++)
        begin
            if ((sirt_pkg::DIGIT_W'(j) < idx_reg)
                && (sirt_pkg::symbol_of(alpha_low, alpha_high, sirt_pkg::DIGIT_W'(j)) == sym_cur))
            begin
                dup = 1'b1;
            end
        end
    end

    always_comb
    begin
        busy_next   = busy_reg;
        idx_next    = idx_reg;
        status.done = 1'b0;
        status.ok   = 1'b0;
        if (busy_reg)
        begin
            if (range_bad || sign_bad || dup)
            begin
                status.done = 1'b1;
                busy_next   = 1'b0;
            end
            else if (at_end)
            begin
                status.done = 1'b1;
                status.ok   = 1'b1;
                busy_next   = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
        else if (start)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

endmodule
